// File: design/isq_pkg.sv
// Package for the indexed sequence store: field widths, request and status codes.
// No dependencies; used by the channel interfaces, the top level and the bench.
`default_nettype none

package isq_pkg;

	localparam int ACTION_W = 2;
	localparam int POS_W    = 9;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [POS_W-1:0]    position_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [COUNT_W-1:0]  count_t;

	localparam action_t ACT_INSERT = 2'd0;
	localparam action_t ACT_READ   = 2'd1;
	localparam action_t ACT_REMOVE = 2'd2;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_FULL  = 2'd2;
	localparam status_t ST_EMPTY = 2'd3;

	localparam value_t VALUE_FAIL = -32'sd1;
	localparam value_t VALUE_NONE = 32'sd0;

endpackage

`default_nettype wire

// File: design/isq_if.sv
// Request and response channel interfaces of the indexed sequence store.
// Depends on isq_pkg for the payload types.
`default_nettype none

interface isq_req_if;
	import isq_pkg::*;
	logic      valid;
	logic      ready;
	action_t   action;
	position_t position;
	value_t    value_in;

	modport source (output valid, action, position, value_in, input ready);
	modport sink   (input valid, action, position, value_in, output ready);
endinterface

interface isq_rsp_if;
	import isq_pkg::*;
	logic    valid;
	logic    ready;
	value_t  value_out;
	status_t status;
	count_t  count_out;

	modport source (output valid, value_out, status, count_out, input ready);
	modport sink   (input valid, value_out, status, count_out, output ready);
endinterface

`default_nettype wire

// File: design/indexed_sequence_store.sv
// Indexed sequence store top level: request decode, shift sequencer and result register.
// Depends on isq_pkg, isq_req_if, isq_rsp_if and isq_ram.
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+-----------------------------------------
//   req     | in  | valid/ready | action, position, value_in
//   rsp     | out | valid/ready | value_out, status, count_out
//
// An insert moves the entries from position up to the tail, a remove those above
// position; none moves for an insert at the tail or a remove of the last entry. The
// entry RAM moves one entry per cycle through its read port and its write port.
// Reset clears the count and the control state; entry contents stay undefined
// until written, and no entry at or above the count is ever read out.
// req is ready only while the sequencer idles; a result waiting in the
// output register does not stop the next transfer, only the next result.
`default_nettype none

module indexed_sequence_store #(
	parameter int CAPACITY = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	isq_req_if.sink   req,
	isq_rsp_if.source rsp
);
	import isq_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [PW-1:0] CAP_EXT = PW'(CAPACITY);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CAPT  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	// Control state
	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_left_q;
	logic          pend_q;
	logic          out_valid_q;

	// Request payload held for the duration of the work
	action_t       act_q;
	logic [AW-1:0] pos_q;
	value_t        val_q;
	status_t       st_q;
	value_t        res_q;
	logic [AW-1:0] src_q;
	logic [AW-1:0] wa_q;

	// Result register
	value_t  out_value_q;
	status_t out_status_q;
	count_t  out_count_q;

	// Decode
	logic          accept;
	logic [PW-1:0] pos_ext;
	logic [PW-1:0] cnt_ext;
	logic          dec_ok;
	status_t       dec_st;
	logic [CW-1:0] dec_left;
	logic [AW-1:0] dec_src;

	// RAM ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	value_t        ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	value_t        ram_rdata;

	logic shift_issue;
	logic shift_done;
	logic out_free;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign pos_ext = PW'(req.position);
	assign cnt_ext = PW'(count_q);

	// Check the request against the count at transfer time.
	always_comb begin
		dec_ok   = 1'b0;
		dec_st   = ST_RANGE;
		dec_left = '0;
		dec_src  = '0;
		case (req.action)
			ACT_INSERT: begin
				if (pos_ext > cnt_ext) begin
					dec_st = ST_RANGE;
				end else if (cnt_ext >= CAP_EXT) begin
					dec_st = ST_FULL;
				end else begin
					dec_ok = 1'b1;
					dec_st = ST_OK;
				end
				// move entries count-1 down to position, top first
				dec_left = CW'(cnt_ext - pos_ext);
				dec_src  = AW'(cnt_ext - PW'(1));
			end
			ACT_READ: begin
				if (pos_ext < cnt_ext) begin
					dec_ok = 1'b1;
					dec_st = ST_OK;
				end
			end
			ACT_REMOVE: begin
				if (count_q == '0) begin
					dec_st = ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					dec_st = ST_RANGE;
				end else begin
					dec_ok = 1'b1;
					dec_st = ST_OK;
				end
				// move entries position+1 up to count-1, bottom first
				dec_left = CW'(cnt_ext - pos_ext - PW'(1));
				dec_src  = AW'(pos_ext + PW'(1));
			end
			default: begin
				dec_ok = 1'b0;
				dec_st = ST_RANGE;
			end
		endcase
	end

	// Shift engine: a read is issued each cycle while moves remain, and the
	// data returned in the next cycle is written one slot up (insert) or down.
	assign shift_issue = (state_q == S_SHIFT) && (rd_left_q != '0);
	assign shift_done  = (state_q == S_SHIFT) && (rd_left_q == '0) && !pend_q;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = src_q;
		if (state_q == S_IDLE) begin
			ram_re    = accept;
			ram_raddr = AW'(req.position);
		end else if (shift_issue) begin
			ram_re    = 1'b1;
			ram_raddr = src_q;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = val_q;
		if ((state_q == S_SHIFT) && pend_q) begin
			ram_we    = 1'b1;
			ram_waddr = wa_q;
			ram_wdata = ram_rdata;
		end else if (shift_done && (act_q == ACT_INSERT)) begin
			// drop the new value into the opened gap
			ram_we    = 1'b1;
			ram_waddr = pos_q;
			ram_wdata = val_q;
		end
	end

	isq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_left_q   <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_left_q <= dec_left;
						pend_q    <= 1'b0;
						if (!dec_ok) begin
							state_q <= S_FIN;
						end else if (req.action == ACT_READ) begin
							state_q <= S_CAPT;
						end else begin
							state_q <= S_SHIFT;
						end
					end
				end
				S_CAPT: begin
					state_q <= S_FIN;
				end
				S_SHIFT: begin
					pend_q <= shift_issue;
					if (shift_issue) begin
						rd_left_q <= rd_left_q - CW'(1);
					end
					if (shift_done) begin
						if (act_q == ACT_INSERT) begin
							count_q <= count_q + CW'(1);
						end else begin
							count_q <= count_q - CW'(1);
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// hold the result until the transfer, reload when a new one is ready
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= req.action;
			pos_q <= AW'(req.position);
			val_q <= req.value_in;
			st_q  <= dec_st;
			res_q <= dec_ok ? VALUE_NONE : VALUE_FAIL;
			src_q <= dec_src;
		end else if (state_q == S_CAPT) begin
			res_q <= ram_rdata;
		end else if (shift_issue) begin
			if (act_q == ACT_INSERT) begin
				src_q <= src_q - AW'(1);
				wa_q  <= src_q + AW'(1);
			end else begin
				src_q <= src_q + AW'(1);
				wa_q  <= src_q - AW'(1);
			end
		end
		if ((state_q == S_FIN) && out_free) begin
			out_value_q  <= res_q;
			out_status_q <= st_q;
			out_count_q  <= COUNT_W'(count_q);
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.value_out = out_value_q;
	assign rsp.status    = out_status_q;
	assign rsp.count_out = out_count_q;

`ifndef SYNTHESIS
	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("count above capacity");

	// The count moves only as a shift finishes.
	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(shift_done))
		else $error("count changed outside a shift");

	// The entry RAM is written only by the shift engine.
	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_SHIFT))
		else $error("entry write outside shift");

	// A failed request reports the failure value.
	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && out_free && (st_q != ST_OK)) |=>
			(rsp.value_out == VALUE_FAIL))
		else $error("failed request without failure value");
`endif

endmodule

`default_nettype wire

// File: design/isq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
`default_nettype none

module isq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: dv/indexed_sequence_store_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for indexed_sequence_store: a directed table, then random streams.
// Depends on isq_pkg, isq_req_if, isq_rsp_if and the design itself.

module indexed_sequence_store_tb;
	import isq_pkg::*;

	localparam int CAPACITY       = 256;
	localparam int DIRECTED_ROWS  = 25;
	localparam int RANDOM_ITEMS   = 1225;
	localparam int PHASE_ITEMS    = 100;
	// Longest legal silence: a full-length shift plus a long receiver stall, taken many times over.
	localparam int WATCHDOG_LIMIT = 20 * (CAPACITY + 3);
	localparam int TAIL_CYCLES    = CAPACITY + 8;
	localparam int POS_TOP        = (1 << POS_W) - 1;

	localparam action_t   ACT_UNUSED = 2'd3;
	localparam value_t    VALUE_MAX  = 32'sh7fffffff;
	localparam value_t    VALUE_MIN  = 32'sh80000000;
	localparam position_t POS_MAX    = '1;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
	typedef enum {DRIFT_FILL, DRIFT_DRAIN, DRIFT_MIX} drift_t;

	typedef struct packed {
		value_t  value;
		status_t status;
		count_t  count;
	} seq_result_t;

	typedef struct packed {
		action_t     action;
		position_t   position;
		value_t      value;
		logic        literal;
		seq_result_t result;
	} stimulus_row_t;

	localparam seq_result_t NO_LITERAL = '{VALUE_NONE, ST_OK, 9'd0};

	logic clk = 1'b0;
	logic arst_n;

	isq_req_if req ();
	isq_rsp_if rsp ();

	indexed_sequence_store #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mirror of the store: the ordered values and how many are held.
	value_t      seq_mirror [CAPACITY];
	count_t      mirror_count = '0;
	seq_result_t awaited_results [$];

	int error_count = 0;
	int send_pct;
	int recv_pct;

	// Set alongside each request; tells the observer to expect the typed-in result.
	logic        row_is_literal;
	seq_result_t row_literal;

	// Directed table. Typed-in results where they follow at a glance; the rest go to the mirror.
	stimulus_row_t directed_rows [DIRECTED_ROWS] = '{
		// empty store: read, remove, unused code, insert past the end
		'{ACT_READ,   9'd0,   VALUE_NONE, 1'b1, '{VALUE_FAIL, ST_RANGE, 9'd0}},
		'{ACT_REMOVE, 9'd0,   VALUE_NONE, 1'b1, '{VALUE_FAIL, ST_EMPTY, 9'd0}},
		'{ACT_UNUSED, 9'd0,   VALUE_MAX,  1'b1, '{VALUE_FAIL, ST_RANGE, 9'd0}},
		'{ACT_INSERT, 9'd1,   VALUE_MAX,  1'b1, '{VALUE_FAIL, ST_RANGE, 9'd0}},
		'{ACT_REMOVE, POS_MAX, VALUE_NONE, 1'b1, '{VALUE_FAIL, ST_EMPTY, 9'd0}},
		// build up: first entry, tail, head, tail, middle
		'{ACT_INSERT, 9'd0,   VALUE_MAX,  1'b1, '{VALUE_NONE, ST_OK, 9'd1}},
		'{ACT_INSERT, 9'd1,   VALUE_MIN,  1'b1, '{VALUE_NONE, ST_OK, 9'd2}},
		'{ACT_INSERT, 9'd0,   VALUE_FAIL, 1'b1, '{VALUE_NONE, ST_OK, 9'd3}},
		'{ACT_INSERT, 9'd3,   VALUE_NONE, 1'b1, '{VALUE_NONE, ST_OK, 9'd4}},
		'{ACT_INSERT, 9'd2,   32'sh5a5a5a5a, 1'b0, NO_LITERAL},
		// reads inside, at the count and at the top position
		'{ACT_READ,   9'd0,   VALUE_NONE, 1'b0, NO_LITERAL},
		'{ACT_READ,   9'd4,   VALUE_NONE, 1'b0, NO_LITERAL},
		'{ACT_READ,   9'd5,   VALUE_NONE, 1'b1, '{VALUE_FAIL, ST_RANGE, 9'd5}},
		'{ACT_READ,   POS_MAX, VALUE_NONE, 1'b1, '{VALUE_FAIL, ST_RANGE, 9'd5}},
		// out-of-range insert and remove
		'{ACT_INSERT, POS_MAX, VALUE_MIN, 1'b1, '{VALUE_FAIL, ST_RANGE, 9'd5}},
		'{ACT_INSERT, 9'd6,   VALUE_MIN,  1'b1, '{VALUE_FAIL, ST_RANGE, 9'd5}},
		'{ACT_REMOVE, 9'd5,   VALUE_NONE, 1'b1, '{VALUE_FAIL, ST_RANGE, 9'd5}},
		'{ACT_REMOVE, POS_MAX, VALUE_NONE, 1'b1, '{VALUE_FAIL, ST_RANGE, 9'd5}},
		// remove head, tail, middle
		'{ACT_REMOVE, 9'd0,   VALUE_NONE, 1'b1, '{VALUE_NONE, ST_OK, 9'd4}},
		'{ACT_REMOVE, 9'd3,   VALUE_NONE, 1'b1, '{VALUE_NONE, ST_OK, 9'd3}},
		'{ACT_REMOVE, 9'd1,   VALUE_NONE, 1'b1, '{VALUE_NONE, ST_OK, 9'd2}},
		'{ACT_READ,   9'd1,   VALUE_NONE, 1'b0, NO_LITERAL},
		'{ACT_UNUSED, POS_MAX, VALUE_FAIL, 1'b1, '{VALUE_FAIL, ST_RANGE, 9'd2}},
		'{ACT_READ,   9'd0,   VALUE_NONE, 1'b0, NO_LITERAL},
		'{ACT_INSERT, 9'd2,   32'sh12345678, 1'b0, NO_LITERAL}
	};

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		error_count++;
	endtask

	// Apply one request to the mirror and return the result the block must give.
	function automatic seq_result_t apply_request(action_t act, position_t pos_in, value_t val);
		seq_result_t res;
		int          pos;
		int          held;
		int          i;
		res.value  = VALUE_FAIL;
		res.status = ST_RANGE;
		pos        = int'(pos_in);
		held       = int'(mirror_count);
		case (act)
			ACT_INSERT: begin
				if (pos > held) begin
					res.status = ST_RANGE;
				end else if (held >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					// open the gap from the tail down
					for (i = held; i > pos; i--)
						seq_mirror[i] = seq_mirror[i-1];
					seq_mirror[pos] = val;
					mirror_count    = count_t'(held + 1);
					res.status      = ST_OK;
					res.value       = VALUE_NONE;
				end
			end
			ACT_READ: begin
				if (pos < held) begin
					res.value  = seq_mirror[pos];
					res.status = ST_OK;
				end
			end
			ACT_REMOVE: begin
				if (held == 0) begin
					res.status = ST_EMPTY;
				end else if (pos >= held) begin
					res.status = ST_RANGE;
				end else begin
					// close the gap towards the head
					for (i = pos; i + 1 < held; i++)
						seq_mirror[i] = seq_mirror[i+1];
					mirror_count = count_t'(held - 1);
					res.status   = ST_OK;
					res.value    = VALUE_NONE;
				end
			end
			default: begin
				// unused code: fail, change nothing
			end
		endcase
		res.count = mirror_count;
		return res;
	endfunction

	// Offer one request at a falling edge; return at the falling edge after its transfer.
	task automatic offer_request(input action_t act, input position_t pos, input value_t val,
			input logic lit, input seq_result_t lit_res);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_pct)
			gap++;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid      <= 1'b1;
		req.action     <= act;
		req.position   <= pos;
		req.value_in   <= val;
		row_is_literal <= lit;
		row_literal    <= lit_res;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid and hold until every awaited result has come back.
	task automatic hold_until_drained();
		req.valid <= 1'b0;
		do
			@(negedge clk);
		while (awaited_results.size() != 0);
	endtask

	// Receiver: decide ready at each falling edge from the current stall rate.
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp.ready <= ($urandom_range(99) >= recv_pct);
		end
	end

	// Observer: on each request transfer advance the mirror; on each result transfer compare.
	always @(posedge clk) begin
		seq_result_t predicted;
		seq_result_t want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				predicted = apply_request(req.action, req.position, req.value_in);
				awaited_results.push_back(row_is_literal ? row_literal : predicted);
			end
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf(
						"result with nothing awaited: value %0d status %0d count %0d",
						rsp.value_out, rsp.status, rsp.count_out));
				end else begin
					want = awaited_results.pop_front();
					if (rsp.value_out !== want.value)
						report_mismatch($sformatf("value_out %0d, wanted %0d",
							rsp.value_out, want.value));
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status %0d, wanted %0d",
							rsp.status, want.status));
					if (rsp.count_out !== want.count)
						report_mismatch($sformatf("count_out %0d, wanted %0d",
							rsp.count_out, want.count));
				end
			end
		end
	end

	// Watchdog: end the run if no transfer happens on either channel for too long.
	int quiet_cycles;
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no transfer for %0d cycles", $time, quiet_cycles);
				$display("indexed_sequence_store_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		action_t   act;
		position_t pos;
		value_t    val;
		int        pick;
		int        hi;
		int        linger;
		int        mix_left;
		drift_t    drift;

		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.action     = ACT_INSERT;
		req.position   = '0;
		req.value_in   = VALUE_NONE;
		row_is_literal = 1'b0;
		row_literal    = NO_LITERAL;
		send_pct       = 0;
		recv_pct       = 0;

		// Hold reset, then release it away from the rising edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, back to back with no idling.
		for (int row = 0; row < DIRECTED_ROWS; row++)
			offer_request(directed_rows[row].action, directed_rows[row].position,
				directed_rows[row].value, directed_rows[row].literal, directed_rows[row].result);

		// Random part. Drift the fill level: fill to capacity and knock on the full store,
		// drain to empty and knock on the empty store, then wander for a while.
		drift    = DRIFT_FILL;
		linger   = 0;
		mix_left = 0;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			// At each phase boundary let everything drain, then change the idling pattern.
			if (k % PHASE_ITEMS == 0) begin
				hold_until_drained();
				case (idle_mode_t'((k / PHASE_ITEMS) % 4))
					IDLE_NONE:     begin send_pct = 0;  recv_pct = 0;  end
					IDLE_SENDER:   begin send_pct = 81; recv_pct = 0;  end
					IDLE_RECEIVER: begin send_pct = 0;  recv_pct = 81; end
					default:       begin send_pct = 14; recv_pct = 14; end
				endcase
			end

			if ($urandom_range(99) < 8) begin
				// noise: any code, any position, unused action included
				act = action_t'($urandom_range(3));
				pos = position_t'($urandom_range(POS_TOP));
			end else begin
				pick = $urandom_range(99);
				case (drift)
					DRIFT_FILL:  act = (pick < 80) ? ACT_INSERT : (pick < 90) ? ACT_READ : ACT_REMOVE;
					DRIFT_DRAIN: act = (pick < 10) ? ACT_INSERT : (pick < 20) ? ACT_READ : ACT_REMOVE;
					default:     act = (pick < 40) ? ACT_INSERT : (pick < 60) ? ACT_READ : ACT_REMOVE;
				endcase
				// highest legal position: count for insert, count-1 otherwise
				if (act == ACT_INSERT)
					hi = int'(mirror_count);
				else
					hi = (mirror_count == 0) ? 0 : int'(mirror_count) - 1;
				pick = $urandom_range(99);
				if (pick < 20)
					pos = '0;
				else if (pick < 40)
					pos = position_t'(hi);
				else
					pos = position_t'($urandom_range(hi));
			end

			if ($urandom_range(99) < 10) begin
				case ($urandom_range(3))
					0:       val = VALUE_MIN;
					1:       val = VALUE_MAX;
					2:       val = VALUE_FAIL;
					default: val = VALUE_NONE;
				endcase
			end else begin
				val = value_t'($urandom);
			end

			offer_request(act, pos, val, 1'b0, NO_LITERAL);

			case (drift)
				DRIFT_FILL: begin
					if (mirror_count == CAPACITY)
						linger++;
					if (linger >= 15) begin
						drift  = DRIFT_DRAIN;
						linger = 0;
					end
				end
				DRIFT_DRAIN: begin
					if (mirror_count == 0)
						linger++;
					if (linger >= 15) begin
						drift    = DRIFT_MIX;
						linger   = 0;
						mix_left = 150;
					end
				end
				default: begin
					mix_left--;
					if (mix_left <= 0)
						drift = DRIFT_FILL;
				end
			endcase
		end

		// Drain, then give any stray result time to show up.
		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("indexed_sequence_store_tb: done, clean");
		else
			$display("indexed_sequence_store_tb: done, errors");
		$finish;
	end

endmodule
